>>> hw/rtl/mgps_pkg.sv
// shared types and constants for the mirrored gait pattern sequencer
// item function codes, register indexes, sequencer states and result fields
// depends on nothing
package mgps_pkg;

    // table geometry defaults
    localparam int DEF_MAX_BLOCKS   = 16;
    localparam int DEF_NUM_CHANNELS = 12;

    // stored activation word width, values are masked to it on write
    localparam int VALUE_BITS = 16;
    localparam logic [15:0] VALUE_MASK =
        (VALUE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << VALUE_BITS) - 32'd1);

    // field widths of the item and result
    localparam int BLOCK_W = 4;
    localparam int SLOT_W  = 4;
    localparam int DUR_W   = 16;
    localparam int ACT_W   = 16;
    localparam int CHAN_W  = 4;
    localparam int STEP_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_CFG_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_STARTUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd2;

    localparam logic [CNT_CFG_W-1:0] STARTUP_RST = 5'd10;
    localparam logic [CNT_CFG_W-1:0] CYCLE_RST   = 5'd6;
    localparam logic [STEP_W-1:0]    TOTAL_RST   = 16'd6000;

    // item function codes
    typedef enum logic [1:0] {
        FN_WR_DUR  = 2'd0,
        FN_WR_VAL  = 2'd1,
        FN_TICK    = 2'd2,
        FN_RESTART = 2'd3
    } func_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOC_RD,
        ST_LOC_EV,
        ST_EMIT
    } seq_state_t;

    // per-result side information carried next to the activation read
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              mirrored;
        logic              finished;
        logic              last;
    } res_ctl_t;

endpackage

>>> hw/rtl/mirrored_gait_pattern_sequencer.sv
// mirrored gait pattern sequencer top level: block table, play sequencer, result stream
// uses mgps_pkg; duration and activation tables are synchronous memories in this module
// table write, config write and restart items complete in the cycle they are accepted
// a tick item walks the table one block step at a time (duration read, then decide), unless
//   past the step limit, then issues one activation read per cycle while the read stage is free
//   or passing its result on; results pass the read stage and the output register to the port
// aresetn (sync, low) clears play position, step count and config to defaults; tables undefined
module mirrored_gait_pattern_sequencer
    import mgps_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // block[3:0], slot[7:4], duration[23:8], value[39:24]
    input  logic [1:0]            s_tuser,   // func[1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // channel[3:0], activation[19:4], zero[23:20]
    output logic [1:0]            m_tuser,   // mirrored[0], finished[1]
    output logic                  m_tlast
);

    // block position needs to hold MAX_BLOCKS itself, table addresses do not
    localparam int BLK_W   = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W  = $clog2(MAX_BLOCKS);
    localparam int DEPTH_V = MAX_BLOCKS * NUM_CHANNELS;
    localparam int VADDR_W = $clog2(DEPTH_V);
    localparam int CH_W    = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HALF_CH = NUM_CHANNELS / 2;
    localparam int SWAP_CH = 2 * HALF_CH;

    // ------------------------------------------------------------------
    // item fields
    // ------------------------------------------------------------------
    func_t              in_func;
    logic [BLOCK_W-1:0] in_block;
    logic [SLOT_W-1:0]  in_slot;
    logic [DUR_W-1:0]   in_dur;
    logic [ACT_W-1:0]   in_value;
    logic               in_acc;
    logic               blk_ok;
    logic               slot_ok;

    assign in_func  = func_t'(s_tuser);
    assign in_block = s_tdata[3:0];
    assign in_slot  = s_tdata[7:4];
    assign in_dur   = s_tdata[23:8];
    assign in_value = s_tdata[39:24];
    assign in_acc   = s_tvalid && s_tready;

    // writes outside the table are dropped
    assign blk_ok  = int'(in_block) < MAX_BLOCKS;
    assign slot_ok = int'(in_slot) < NUM_CHANNELS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CNT_CFG_W-1:0] startup_reg;
    logic [CNT_CFG_W-1:0] cycle_reg;
    logic [STEP_W-1:0]    total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_reg <= STARTUP_RST;
            cycle_reg   <= CYCLE_RST;
            total_reg   <= TOTAL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STARTUP: startup_reg <= cfg_wdata[CNT_CFG_W-1:0];
                REG_CYCLE:   cycle_reg   <= cfg_wdata[CNT_CFG_W-1:0];
                REG_TOTAL:   total_reg   <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // effective startup count saturates at the table size, the cycle count
    // is clipped to the room that is left behind it
    logic [BLK_W-1:0]      s_eff;
    logic [BLK_W-1:0]      room;
    logic [BLK_W-1:0]      c_eff;
    logic [BLK_W-1:0]      end_blk;
    logic [MAX_BLOCKS-1:0] cyc_mask;

    always_comb begin
        s_eff   = (int'(startup_reg) > MAX_BLOCKS) ? BLK_W'(MAX_BLOCKS) : BLK_W'(startup_reg);
        room    = BLK_W'(MAX_BLOCKS) - s_eff;
        c_eff   = (int'(cycle_reg) > int'(room)) ? room : BLK_W'(cycle_reg);
        end_blk = s_eff + c_eff;
        for (int b = 0; b < MAX_BLOCKS; b++) begin
            cyc_mask[b] = (b >= int'(s_eff)) && (b < int'(end_blk));
        end
    end

    // ------------------------------------------------------------------
    // state machine and sequencer registers
    // ------------------------------------------------------------------
    seq_state_t state_reg, state_next;

    logic [STEP_W-1:0] step_reg, step_next;   // ticks played so far
    logic [BLK_W-1:0]  cur_reg, cur_next;     // block on play
    logic [DUR_W-1:0]  tib_reg, tib_next;     // ticks played in that block
    logic              cyc_reg, cyc_next;     // in the repeating phase
    logic              odd_reg, odd_next;     // odd repeat, halves swapped
    logic              play_reg, play_next;   // tick being emitted plays the pattern
    logic              mir_reg, mir_next;     // tick being emitted is mirrored
    logic [CH_W-1:0]   ch_reg;                // next channel to read
    logic              loc_more;              // walk needs another block step

    // control strobes
    logic dur_we;
    logic val_we;
    logic dur_re;
    logic rd_issue;
    logic out_load;

    // duration memory and its nonzero flags (for the empty-cycle check)
    logic [DUR_W-1:0]      dur_mem [MAX_BLOCKS];
    logic [DUR_W-1:0]      dur_rd;
    logic [MAX_BLOCKS-1:0] nz_reg;
    logic [ADDR_W-1:0]     dur_wr_addr;
    logic                  any_cyc;

    assign dur_wr_addr = ADDR_W'(in_block);
    assign any_cyc     = |(nz_reg & cyc_mask);

    // read stage of the activation memory
    logic [ACT_W-1:0]   val_mem [DEPTH_V];
    logic [ACT_W-1:0]   val_rd;
    logic [VADDR_W-1:0] val_wr_addr;
    logic [VADDR_W-1:0] val_rd_addr;
    logic [CH_W-1:0]    src_ch;
    logic               rd_valid_reg;
    res_ctl_t           rd_ctl_reg;
    res_ctl_t           issue_ctl;

    // output register
    logic               m_valid_reg;
    res_ctl_t           m_ctl_reg;
    logic [ACT_W-1:0]   m_act_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (in_func == FN_TICK)) begin
                    // past the step limit the walk is skipped
                    state_next = (step_reg < total_reg) ? ST_LOC_RD : ST_EMIT;
                end
            end
            ST_LOC_RD: state_next = ST_LOC_EV;
            ST_LOC_EV: state_next = loc_more ? ST_LOC_RD : ST_EMIT;
            ST_EMIT: begin
                if (rd_issue && (ch_reg == CH_W'(NUM_CHANNELS - 1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_tready = 1'b0;
        dur_we   = 1'b0;
        val_we   = 1'b0;
        dur_re   = 1'b0;
        rd_issue = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no item is taken while reset is held
                s_tready = aresetn;
                if (in_acc) begin
                    unique case (in_func)
                        FN_WR_DUR: dur_we = blk_ok;
                        FN_WR_VAL: val_we = blk_ok && slot_ok;
                        default: ;
                    endcase
                end
            end
            ST_LOC_RD: dur_re = 1'b1;
            ST_LOC_EV: ;
            ST_EMIT:   rd_issue = !rd_valid_reg || out_load;
            default: ;
        endcase
    end

    // one step of the table walk per evaluation cycle
    always_comb begin
        logic found;
        found     = 1'b0;
        loc_more  = 1'b0;
        step_next = step_reg;
        cur_next  = cur_reg;
        tib_next  = tib_reg;
        cyc_next  = cyc_reg;
        odd_next  = odd_reg;
        play_next = play_reg;
        mir_next  = mir_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (in_func == FN_RESTART)) begin
                    step_next = '0;
                    cur_next  = '0;
                    tib_next  = '0;
                    cyc_next  = 1'b0;
                    odd_next  = 1'b1;
                end
                if (in_acc && (in_func == FN_TICK)) begin
                    // finished unless the walk finds a block
                    play_next = 1'b0;
                    mir_next  = 1'b0;
                end
            end
            ST_LOC_EV: begin
                if (!cyc_reg) begin
                    if (cur_reg < s_eff) begin
                        if (tib_reg < dur_rd) begin
                            found = 1'b1;
                        end else begin
                            cur_next = cur_reg + BLK_W'(1);
                            tib_next = '0;
                            loc_more = 1'b1;
                        end
                    end else begin
                        // startup done, enter the repeating phase
                        cyc_next = 1'b1;
                        cur_next = s_eff;
                        tib_next = '0;
                        odd_next = 1'b1;
                        loc_more = 1'b1;
                    end
                end else if (!any_cyc) begin
                    // nothing in the cycle can play: finished tick, nothing advances
                    found = 1'b0;
                end else if ((cur_reg < s_eff) || (cur_reg >= end_blk)) begin
                    // wrap to the first cycle block, flips the repeat parity
                    cur_next = s_eff;
                    tib_next = '0;
                    odd_next = !odd_reg;
                    loc_more = 1'b1;
                end else if (tib_reg < dur_rd) begin
                    found = 1'b1;
                end else begin
                    cur_next = cur_reg + BLK_W'(1);
                    tib_next = '0;
                    loc_more = 1'b1;
                end
                if (found) begin
                    play_next = 1'b1;
                    mir_next  = cyc_reg && odd_reg;
                    tib_next  = tib_reg + DUR_W'(1);
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cur_reg   <= '0;
            tib_reg   <= '0;
            cyc_reg   <= 1'b0;
            odd_reg   <= 1'b1;
            play_reg  <= 1'b0;
            mir_reg   <= 1'b0;
            ch_reg    <= '0;
            nz_reg    <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cur_reg   <= cur_next;
            tib_reg   <= tib_next;
            cyc_reg   <= cyc_next;
            odd_reg   <= odd_next;
            play_reg  <= play_next;
            mir_reg   <= mir_next;
            if (rd_issue) begin
                ch_reg <= (ch_reg == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch_reg + CH_W'(1);
            end
            if (dur_we) begin
                nz_reg[dur_wr_addr] <= |in_dur;
            end
        end
    end

    // ------------------------------------------------------------------
    // duration memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (dur_we) begin
            dur_mem[dur_wr_addr] <= in_dur;
        end
        if (dur_re) begin
            dur_rd <= dur_mem[cur_reg[ADDR_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // activation memory, unless the read stage is held, read one channel per cycle while emitting
    // ------------------------------------------------------------------
    // a mirrored tick reads the other half; an odd last channel stays put
    always_comb begin
        src_ch = ch_reg;
        if (mir_reg && (int'(ch_reg) < SWAP_CH)) begin
            src_ch = (int'(ch_reg) < HALF_CH) ? ch_reg + CH_W'(HALF_CH)
                                              : ch_reg - CH_W'(HALF_CH);
        end
    end

    assign val_wr_addr = VADDR_W'(int'(in_block) * NUM_CHANNELS + int'(in_slot));
    assign val_rd_addr = VADDR_W'(int'(cur_reg) * NUM_CHANNELS + int'(src_ch));

    always_comb begin
        issue_ctl.channel  = CHAN_W'(ch_reg);
        issue_ctl.mirrored = mir_reg;
        issue_ctl.finished = !play_reg;
        issue_ctl.last     = (ch_reg == CH_W'(NUM_CHANNELS - 1));
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_wr_addr] <= in_value & VALUE_MASK;
        end
        // a finished tick does not touch the table, its activation is forced to zero
        if (rd_issue && play_reg) begin
            val_rd <= val_mem[val_rd_addr];
        end
    end

    // read stage holds one result until the output register can take it
    assign out_load = rd_valid_reg && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (rd_issue) begin
            rd_valid_reg <= 1'b1;
        end else if (out_load) begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_ctl_reg <= issue_ctl;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_ctl_reg <= rd_ctl_reg;
            m_act_reg <= rd_ctl_reg.finished ? '0 : val_rd;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_act_reg, m_ctl_reg.channel};
    assign m_tuser  = {m_ctl_reg.finished, m_ctl_reg.mirrored};
    assign m_tlast  = m_ctl_reg.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a playing tick being emitted always points at a real table block
    a_play_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && play_reg |-> (int'(cur_reg) < MAX_BLOCKS))
        else $error("playing tick outside the block table");

    // the channel counter is back at zero whenever no tick is being emitted
    a_ch_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EMIT) |-> (ch_reg == '0))
        else $error("channel counter not rewound after a tick");

    // a pending read result is never overwritten before it moves on
    a_rd_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg && !out_load |-> !rd_issue)
        else $error("activation read overruns the read stage");

    // a finished result carries neither mirroring nor activation
    a_finished_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata[19:4] == '0))
        else $error("finished result with mirror or activation");

    // a loaded last result shows on the port in the next cycle
    a_last_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && rd_ctl_reg.last |=> m_tvalid && m_tlast)
        else $error("last result lost on the way to the port");

endmodule
